// ===== hw/rtl/kmh_pkg.sv =====
package kmh_pkg;

    // Input item: one base byte or one bin read
    typedef struct packed {
        logic       func;
        logic [7:0] base_byte;
        logic [11:0] bin_index;
    } item_t;

    // Result item: the bin read and its count before clearing
    typedef struct packed {
        logic [11:0] bin_number;
        logic [31:0] bin_count;
    } result_t;

    // Memory operation handed from the window logic to the histogram
    typedef struct packed {
        logic valid;
        logic clear;
    } kmh_op_t;

    // Histogram status seen by the top level
    typedef struct packed {
        logic busy;
        logic read_pending;
    } kmh_stat_t;

    localparam logic FUNC_FEED = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam int unsigned KLEN_W = 3;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 3'd6;

    localparam logic [7:0] CHAR_A  = 8'h41;
    localparam logic [7:0] CHAR_C  = 8'h43;
    localparam logic [7:0] CHAR_G  = 8'h47;
    localparam logic [7:0] CHAR_T  = 8'h54;
    localparam logic [7:0] CHAR_NL = 8'h0A;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

endpackage

// ===== hw/rtl/kmh_window.sv =====
module kmh_window
    import kmh_pkg::*;
#(
    parameter int MAX_KMER = 6,
    parameter int ADDR_W   = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [KLEN_W-1:0] cfg_wr_data,
    input  item_t             item,
    input  logic              accept,
    output kmh_op_t           op,
    output logic [ADDR_W-1:0] op_addr
);

    localparam int RUN_W = $clog2(MAX_KMER + 1);

    logic [KLEN_W-1:0] kmer_length_reg;
    logic [ADDR_W-1:0] window_reg;
    logic [ADDR_W-1:0] window_next;
    logic [RUN_W-1:0]  run_reg;
    logic [RUN_W-1:0]  run_next;

    logic [3:0]        k_len;
    logic [3:0]        len_ext;
    logic [3:0]        run_ext;
    logic [3:0]        run_inc;
    logic [1:0]        code;
    logic              code_ok;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W+1:0] shifted;
    logic [ADDR_W+11:0] bin_ext;

    // Clamp the programmed length to 1..MAX_KMER
    always_comb
    begin
        len_ext = 4'(kmer_length_reg);
        if (len_ext == 4'd0)
            k_len = 4'd1;
        else if (len_ext > 4'(MAX_KMER))
            k_len = 4'(MAX_KMER);
        else
            k_len = len_ext;
    end

    // Decode one uppercase base
    always_comb
    begin
        code_ok = 1'b1;
        case (item.base_byte)
            CHAR_A:  code = CODE_A;
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default:
            begin
                code    = CODE_A;
                code_ok = 1'b0;
            end
        endcase
    end

    // Keep only the last k bases of the window
    always_comb
    begin
        for (int j = 0; j < MAX_KMER; j++)
            mask[2*j +: 2] = (4'(j) < k_len) ? 2'b11 : 2'b00;
    end

    assign shifted     = {window_reg, code};
    assign window_next = shifted[ADDR_W-1:0] & mask;
    assign run_ext     = 4'(run_reg);
    assign run_inc     = (run_ext < k_len) ? run_ext + 4'd1 : run_ext;
    assign run_next    = RUN_W'(run_inc);
    assign bin_ext     = {ADDR_W'(0), item.bin_index};

    // Pick the memory operation for the item in transfer
    always_comb
    begin
        op.valid = 1'b0;
        op.clear = 1'b0;
        op_addr  = window_next;
        if (accept)
        begin
            if (item.func == FUNC_READ)
            begin
                op.valid = 1'b1;
                op.clear = 1'b1;
                op_addr  = bin_ext[ADDR_W-1:0];
            end
            else if (item.base_byte != CHAR_NL && code_ok)
            begin
                op.valid = (run_inc >= k_len);
            end
        end
    end

    // Advance the rolling window; restart on reads, bad bytes and length writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KLEN_RESET;
            window_reg      <= '0;
            run_reg         <= '0;
        end
        else if (cfg_wr_en)
        begin
            kmer_length_reg <= cfg_wr_data;
            window_reg      <= '0;
            run_reg         <= '0;
        end
        else if (accept)
        begin
            if (item.func == FUNC_READ)
            begin
                window_reg <= '0;
                run_reg    <= '0;
            end
            else if (item.base_byte != CHAR_NL)
            begin
                if (code_ok)
                begin
                    window_reg <= window_next;
                    run_reg    <= run_next;
                end
                else
                begin
                    window_reg <= '0;
                    run_reg    <= '0;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/kmh_hist.sv =====
module kmh_hist
    import kmh_pkg::*;
#(
    parameter int ADDR_W     = 12,
    parameter int COUNT_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  kmh_op_t               op,
    input  logic [ADDR_W-1:0]     op_addr,
    output kmh_stat_t             stat,
    output logic [ADDR_W-1:0]     res_addr,
    output logic [COUNT_BITS-1:0] res_count
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [COUNT_BITS-1:0] hist_mem [DEPTH];

    logic [ADDR_W:0]       clr_cnt_reg;
    logic                  clearing;

    kmh_op_t               s1_op_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  fwd_valid_reg;
    logic [ADDR_W-1:0]     fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] upd;
    logic                  s1_we;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    assign clearing = !clr_cnt_reg[ADDR_W];

    // Take the bin written by the previous update when the memory read missed it
    assign cur = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : rd_data_reg;

    // Clear on read, otherwise saturating increment
    always_comb
    begin
        if (s1_op_reg.clear)
            upd = '0;
        else if (cur == {COUNT_BITS{1'b1}})
            upd = cur;
        else
            upd = cur + COUNT_BITS'(1);
    end

    assign s1_we     = s1_op_reg.valid && adv;
    assign mem_we    = clearing || s1_we;
    assign mem_waddr = clearing ? clr_cnt_reg[ADDR_W-1:0] : s1_addr_reg;
    assign mem_wdata = clearing ? '0 : upd;

    assign stat.busy         = clearing;
    assign stat.read_pending = s1_op_reg.valid && s1_op_reg.clear;
    assign res_addr          = s1_addr_reg;
    assign res_count         = cur;

    // Write back and read the next bin
    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[mem_waddr] <= mem_wdata;
        if (adv)
            rd_data_reg <= hist_mem[op_addr];
    end

    // Sweep the memory to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clearing)
            clr_cnt_reg <= clr_cnt_reg + (ADDR_W+1)'(1);
    end

    // Advance the read-modify-write stage and the forward register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_op_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_op_reg     <= op;
            fwd_valid_reg <= s1_op_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_addr_reg  <= op_addr;
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= upd;
        end
    end

endmodule

// ===== hw/rtl/kmer_histogram_counter_top.sv =====
// K-mer histogram counter. Feed one ASCII base per transfer (func 0) and the block
// keeps a rolling window of the last k bases, incrementing that k-mer's saturating
// counter; a read transfer (func 1) returns one bin's count, clears the bin and
// restarts the window. Items are taken at one per cycle while the input does not
// stall: each does a single read-modify-write of the histogram RAM (registered
// read, write back from the update stage, forwarding for back-to-back hits on one
// bin). A read result goes through the update stage to the output register. Input
// stalls during the RAM clear, else only while a result waits on the output and a
// second read sits in the update stage. After reset the RAM is zeroed in a sweep of
// all 4^MAX_KMER bins (4096 by default); kmer_length writes are taken at any time.
module kmer_histogram_counter_top
    import kmh_pkg::*;
#(
    parameter int MAX_KMER   = 6,
    parameter int COUNT_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [KLEN_W-1:0] cfg_wr_data,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    localparam int ADDR_W = 2 * MAX_KMER;

    kmh_op_t               op;
    logic [ADDR_W-1:0]     op_addr;
    kmh_stat_t             stat;
    logic [ADDR_W-1:0]     res_addr;
    logic [COUNT_BITS-1:0] res_count;
    logic                  adv;
    logic                  accept;
    logic [ADDR_W+11:0]    addr_ext;
    logic [COUNT_BITS+31:0] count_ext;

    logic                  out_valid_reg;
    result_t               out_data_reg;

    // Hold the pipe only when a second read result has nowhere to go
    assign adv        = !(stat.read_pending && out_valid_reg && !result_ready);
    assign item_ready = adv && !stat.busy;
    assign accept     = item_valid && item_ready;

    kmh_window #(
        .MAX_KMER (MAX_KMER),
        .ADDR_W   (ADDR_W)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .accept      (accept),
        .op          (op),
        .op_addr     (op_addr)
    );

    kmh_hist #(
        .ADDR_W     (ADDR_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .op        (op),
        .op_addr   (op_addr),
        .stat      (stat),
        .res_addr  (res_addr),
        .res_count (res_count)
    );

    assign addr_ext  = {12'b0, res_addr};
    assign count_ext = {32'b0, res_count};

    // Load the output register from a finished read, drop it on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && stat.read_pending)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && stat.read_pending)
        begin
            out_data_reg.bin_number <= addr_ext[11:0];
            out_data_reg.bin_count  <= count_ext[31:0];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // No transfer while the RAM is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !item_ready)
        else $error("item accepted during clearing sweep");

    // A read transfer reaches the update stage next cycle
    a_read_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.func == FUNC_READ) |=> stat.read_pending)
        else $error("read transfer lost before update stage");

    // A result only comes from a read in the update stage
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(stat.read_pending))
        else $error("result raised without a pending read");

endmodule

// ===== tb/sv/tb_kmer_histogram_counter_top.sv =====
`timescale 1ns / 100ps

module tb_kmer_histogram_counter_top;
    import kmh_pkg::*;

    localparam int unsigned MAX_K = 6;
    localparam int unsigned BINS = 4096;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 64;
    localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;

    // One directed row: the item plus an optional typed-in expected count
    typedef struct packed {
        logic        func;
        logic [7:0]  base_byte;
        logic [11:0] bin_index;
        logic        typed;
        logic [31:0] typed_count;
    } script_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [KLEN_W-1:0] cfg_wr_data;
    logic              item_valid;
    logic              item_ready;
    item_t             item;
    logic              result_valid;
    logic              result_ready;
    result_t           result;

    // Predicted block state
    logic [31:0]       bin_tally [BINS];
    logic [11:0]       recent_bases;
    int unsigned       run_bases;
    logic [KLEN_W-1:0] kmer_len;

    // Reads still owed by the block, oldest first
    result_t           reads_due [$];

    int unsigned       error_count;
    int unsigned       cycle_count;
    int unsigned       feeds_sent;
    int unsigned       reads_sent;
    int unsigned       reads_checked;
    int unsigned       nonzero_reads;
    int unsigned       settings_used;
    int unsigned       hold_requests;
    bit                idle_on;

    logic [7:0] base_chars [4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

    // Reset-time k, newline and broken windows, short runs, extreme bins
    script_row_t directed_rows [0:21] = '{
        '{FUNC_READ, 8'h00,   12'h000, 1'b1, 32'd0},
        '{FUNC_READ, 8'hFF,   12'hFFF, 1'b1, 32'd0},
        '{FUNC_FEED, CHAR_A,  12'hFFF, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_C,  12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_G,  12'hAAA, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_T,  12'h555, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_A,  12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_C,  12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_NL, 12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_G,  12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, 8'h61,   12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, 8'hFF,   12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, 8'h00,   12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_T,  12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_T,  12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_T,  12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_T,  12'h000, 1'b0, 32'd0},
        '{FUNC_FEED, CHAR_T,  12'h000, 1'b0, 32'd0},
        '{FUNC_READ, 8'h00,   12'hFFF, 1'b1, 32'd0},
        '{FUNC_READ, 8'h00,   12'h1B1, 1'b0, 32'd0},
        '{FUNC_READ, 8'h00,   12'h6C6, 1'b0, 32'd0},
        '{FUNC_READ, 8'h00,   12'h1B1, 1'b0, 32'd0}
    };

    logic [2:0] phase_lengths [8] = '{3'd1, 3'd7, 3'd0, 3'd3, 3'd6, 3'd2, 3'd5, 3'd4};

    kmer_histogram_counter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reads outstanding", cycle_count,
                     reads_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 30)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Clamp the register value to the usable k range
    function automatic int unsigned active_k();
        if (kmer_len == 0)
            return 1;
        if (kmer_len > MAX_K)
            return MAX_K;
        return kmer_len;
    endfunction

    // Advance the predicted state by one item; return the read result if any
    function automatic void count_kmer(input item_t it, output bit produced,
                                       output result_t res);
        int unsigned k;
        logic [11:0] mask;
        logic [1:0]  code;
        bit          is_base;
        produced = 1'b0;
        res = '0;
        if (it.func == FUNC_READ)
        begin
            res.bin_number = it.bin_index;
            res.bin_count = bin_tally[it.bin_index];
            bin_tally[it.bin_index] = '0;
            recent_bases = '0;
            run_bases = 0;
            produced = 1'b1;
            return;
        end
        if (it.base_byte == CHAR_NL)
            return;
        is_base = 1'b1;
        code = CODE_A;
        case (it.base_byte)
            CHAR_A: code = CODE_A;
            CHAR_C: code = CODE_C;
            CHAR_G: code = CODE_G;
            CHAR_T: code = CODE_T;
            default: is_base = 1'b0;
        endcase
        if (!is_base)
        begin
            recent_bases = '0;
            run_bases = 0;
            return;
        end
        k = active_k();
        mask = 12'((32'd1 << (2 * k)) - 1);
        recent_bases = ((recent_bases << 2) | 12'(code)) & mask;
        if (run_bases < k)
            run_bases++;
        if (run_bases >= k && bin_tally[recent_bases] != COUNT_TOP)
            bin_tally[recent_bases] = bin_tally[recent_bases] + 1;
    endfunction

    // Offer one item, hold it until the transfer, then maybe idle
    task automatic send_item(input item_t it, input bit typed, input logic [31:0] typed_count);
        bit      produced;
        result_t res;
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        count_kmer(it, produced, res);
        if (produced)
        begin
            if (typed)
                res.bin_count = typed_count;
            reads_due.push_back(res);
            reads_sent++;
        end
        else
            feeds_sent++;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Drain all owed reads, let trailing feeds retire, then write k
    task automatic write_klen(input logic [KLEN_W-1:0] value);
        item_valid <= 1'b0;
        while (reads_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        kmer_len = value;
        recent_bases = '0;
        run_bases = 0;
        settings_used++;
    endtask

    // Pick a bin to read: half the time the current window, else in the k range or anywhere
    function automatic logic [11:0] pick_bin();
        int unsigned sel;
        sel = $urandom_range(0, 3);
        if (sel < 2)
            return recent_bases;
        if (sel == 2)
            return 12'($urandom_range(0, (1 << (2 * active_k())) - 1));
        return 12'($urandom_range(0, BINS - 1));
    endfunction

    // Mostly clean base runs, with newlines, lowercase, noise and reads mixed in
    task automatic run_phase(input logic [KLEN_W-1:0] k, input int unsigned count);
        item_t       it;
        int unsigned pick;
        write_klen(k);
        for (int unsigned i = 0; i < count; i++)
        begin
            it.func = FUNC_FEED;
            it.bin_index = 12'($urandom_range(0, BINS - 1));
            it.base_byte = base_chars[$urandom_range(0, 3)];
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                it.func = FUNC_READ;
                it.base_byte = 8'($urandom_range(0, 255));
                it.bin_index = pick_bin();
            end
            else if (pick < 82)
                it.base_byte = base_chars[$urandom_range(0, 3)];
            else if (pick < 88)
                it.base_byte = CHAR_NL;
            else if (pick < 93)
                it.base_byte = base_chars[$urandom_range(0, 3)] | 8'h20;
            else
                it.base_byte = 8'($urandom_range(0, 255));
            send_item(it, 1'b0, '0);
        end
    endtask

    // Result sink: random stall bursts plus one long hold on request
    initial
    begin : result_sink
        int unsigned gap_left;
        int unsigned hold_left;
        int unsigned hold_seen;
        gap_left = 0;
        hold_left = 0;
        hold_seen = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                result_ready <= 1'b0;
                gap_left--;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                result_ready <= 1'b0;
                gap_left = $urandom_range(1, 14) - 1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Check each result transfer against the oldest owed read
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (reads_due.size() == 0)
                report_mismatch($sformatf("unexpected result bin %0h count %0d",
                                          result.bin_number, result.bin_count));
            else
            begin
                want = reads_due.pop_front();
                reads_checked++;
                if (result.bin_count != 0)
                    nonzero_reads++;
                if (result.bin_number !== want.bin_number)
                    report_mismatch($sformatf("bin_number %0h, wanted %0h",
                                              result.bin_number, want.bin_number));
                if (result.bin_count !== want.bin_count)
                    report_mismatch($sformatf("bin %0h count %0d, wanted %0d",
                                              want.bin_number, result.bin_count,
                                              want.bin_count));
            end
        end
    end

    // Main sequence
    initial
    begin : stimulus
        item_t it;
        error_count = 0;
        cycle_count = 0;
        feeds_sent = 0;
        reads_sent = 0;
        reads_checked = 0;
        nonzero_reads = 0;
        settings_used = 1;
        hold_requests = 0;
        idle_on = 1'b1;
        for (int i = 0; i < BINS; i++)
            bin_tally[i] = '0;
        recent_bases = '0;
        run_bases = 0;
        kmer_len = KLEN_RESET;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        item_valid <= 1'b0;
        item <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed rows at the reset value of k
        for (int i = 0; i < $size(directed_rows); i++)
        begin
            it.func = directed_rows[i].func;
            it.base_byte = directed_rows[i].base_byte;
            it.bin_index = directed_rows[i].bin_index;
            send_item(it, directed_rows[i].typed, directed_rows[i].typed_count);
        end

        // Sweep k settings, extremes and out-of-range values included
        for (int p = 0; p < $size(phase_lengths); p++)
        begin
            if (p == $size(phase_lengths) - 1)
                idle_on = 1'b0;
            run_phase(phase_lengths[p], 48);
            if (p == 3)
            begin
                // Hold the output long while reads keep coming, to back up the input
                hold_requests++;
                for (int j = 0; j < 12; j++)
                begin
                    it.func = FUNC_READ;
                    it.base_byte = 8'($urandom_range(0, 255));
                    it.bin_index = pick_bin();
                    send_item(it, 1'b0, '0);
                end
            end
        end

        // Drain and let the pipeline settle
        item_valid <= 1'b0;
        while (reads_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d base transfers and %0d bin reads across %0d k settings,",
                 feeds_sent, reads_sent, settings_used);
        $display("checked %0d read results (%0d nonzero), with one long output hold.",
                 reads_checked, nonzero_reads);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
